### design/bba_pkg.sv
// shared types and constants for the bitmap block allocator
// no dependencies; imported by bba_lowfree and bitmap_block_allocator_unit
package bba_pkg;

    localparam int ID_W     = 10;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // outcome of the lowest free bit search over one bitmap word
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_find;

endpackage

### design/bba_lowfree.sv
// lowest free bit search over one bitmap word, with padding of the last word
// depends on bba_pkg (t_find)
module bba_lowfree import bba_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int LAST_BITS = 32
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_last,
    output t_find                o_find,
    output logic [WORD_BITS-1:0] o_onehot
);

    logic [WORD_BITS-1:0] s_pad;
    logic [WORD_BITS-1:0] s_eff;
    logic [POS_W-1:0]     s_pos;

    // bits past the last valid block count as used
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            s_pad[i] = (i >= LAST_BITS);
        end
    end

    assign s_eff    = i_word | (i_last ? s_pad : '0);
    // isolate the lowest zero bit with one add
    assign o_onehot = ~s_eff & (s_eff + WORD_BITS'(1));

    // encode the one-hot position
    always_comb begin
        s_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (o_onehot[i]) begin
                s_pos = s_pos | POS_W'(i);
            end
        end
    end

    assign o_find.found = |o_onehot;
    assign o_find.pos   = s_pos;

endmodule

### design/bitmap_block_allocator_unit.sv
// first-fit block allocator over a one-bit-per-block usage bitmap in a word memory
// depends on bba_pkg and bba_lowfree
// allocate: one bitmap word read per cycle from word 0; free: read, clear bit, write back;
// out-of-range free: strobe from idle. busy is high until the result strobe, low for an
// out-of-range free; one item at a time. reset (synchronous, active low) clears NUM_WORDS
// words one per cycle, busy high; the result strobe lasts one cycle and cannot be stalled
module bitmap_block_allocator_unit import bba_pkg::*; #(
    parameter int NUM_BLOCKS = 1024,
    parameter int WORD_BITS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [ID_W-1:0]     i_block_id,
    output logic                o_strobe,
    output logic [ID_W-1:0]     o_alloc_id,
    output logic [STATUS_W-1:0] o_status
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;
    localparam int BASE_W    = $clog2(NUM_BLOCKS + WORD_BITS) + 1;
    localparam int RECIP     = 65536 / WORD_BITS;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FDIV = 3'd3;
    localparam logic [2:0] S_FREM = 3'd4;
    localparam logic [2:0] S_FWR  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic [BASE_W-1:0]    r_base, n_base;
    logic [ID_W-1:0]      r_id, n_id;
    logic [ID_W-1:0]      r_q, n_q;
    logic [POS_W-1:0]     r_bit, n_bit;
    logic                 r_strobe, n_strobe;
    logic [ID_W-1:0]      r_alloc_id, n_alloc_id;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [AW-1:0]        s_rd_addr;
    logic                 s_we;
    logic [AW-1:0]        s_wa;
    logic [WORD_BITS-1:0] s_wd;

    logic                 s_last;
    t_find                s_find;
    logic [WORD_BITS-1:0] s_onehot;
    logic [BASE_W-1:0]    s_blk;
    logic [23:0]          s_qmul;
    logic [15:0]          s_prod;
    logic [15:0]          s_rem;
    logic [ID_W-1:0]      s_qc;
    logic [15:0]          s_remc;

    assign s_last = (r_addr == AW'(NUM_WORDS - 1));

    bba_lowfree #(
        .WORD_BITS (WORD_BITS),
        .LAST_BITS (LAST_BITS)
    ) u_lowfree (
        .i_word   (r_rdata),
        .i_last   (s_last),
        .o_find   (s_find),
        .o_onehot (s_onehot)
    );

    assign s_blk  = r_base + BASE_W'(s_find.pos);

    // reciprocal estimate of id / WORD_BITS, then one correction step
    assign s_qmul = 24'(r_id) * 24'(RECIP);
    assign s_prod = 16'(r_q) * 16'(WORD_BITS);
    assign s_rem  = 16'(r_id) - s_prod;

    always_comb begin
        if (s_rem >= 16'(WORD_BITS)) begin
            s_qc   = r_q + ID_W'(1);
            s_remc = s_rem - 16'(WORD_BITS);
        end else begin
            s_qc   = r_q;
            s_remc = s_rem;
        end
    end

    // bitmap word memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wa] <= s_wd;
        end
        r_rdata <= r_mem[s_rd_addr];
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_base     = r_base;
        n_id       = r_id;
        n_q        = r_q;
        n_bit      = r_bit;
        n_strobe   = 1'b0;
        n_alloc_id = r_alloc_id;
        n_status   = r_status;
        s_rd_addr  = r_addr;
        s_we       = 1'b0;
        s_wa       = r_addr;
        s_wd       = '0;
        case (r_state)
            S_CLR: begin
                s_we = 1'b1;
                if (s_last) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_ALLOC) begin
                        s_rd_addr = '0;
                        n_addr    = '0;
                        n_base    = '0;
                        n_state   = S_SCAN;
                    end else if (32'(i_block_id) >= 32'(NUM_BLOCKS)) begin
                        n_strobe   = 1'b1;
                        n_alloc_id = '0;
                        n_status   = ST_RANGE;
                    end else begin
                        n_id    = i_block_id;
                        n_state = S_FDIV;
                    end
                end
            end
            S_SCAN: begin
                // r_rdata holds word r_addr; fetch the next one meanwhile
                s_rd_addr = r_addr + AW'(1);
                if (s_find.found) begin
                    s_we       = 1'b1;
                    s_wd       = r_rdata | s_onehot;
                    n_strobe   = 1'b1;
                    n_alloc_id = ID_W'(s_blk);
                    n_status   = ST_OK;
                    n_state    = S_IDLE;
                end else if (s_last) begin
                    n_strobe   = 1'b1;
                    n_alloc_id = '0;
                    n_status   = ST_FULL;
                    n_state    = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_base = r_base + BASE_W'(WORD_BITS);
                end
            end
            S_FDIV: begin
                n_q     = ID_W'(s_qmul >> 16);
                n_state = S_FREM;
            end
            S_FREM: begin
                s_rd_addr = AW'(s_qc);
                n_addr    = AW'(s_qc);
                n_bit     = POS_W'(s_remc);
                n_state   = S_FWR;
            end
            S_FWR: begin
                s_we       = 1'b1;
                s_wd       = r_rdata & ~(WORD_BITS'(1) << r_bit);
                n_strobe   = 1'b1;
                n_alloc_id = '0;
                n_status   = ST_OK;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
                n_addr  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_id       <= n_id;
        r_q        <= n_q;
        r_bit      <= n_bit;
        r_alloc_id <= n_alloc_id;
        r_status   <= n_status;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_alloc_id = r_alloc_id;
    assign o_status   = r_status;

endmodule
